FILE: hdl/mrtu_pkg.sv
// ---------------------------------------------------------------------------
// Modbus RTU frame engine package
// Shared types, constants and a helper function for the frame engine.
// ---------------------------------------------------------------------------
package mrtu_pkg;

  localparam int DEF_HOLDING_REGS  = 64;
  localparam int DEF_INPUT_REGS    = 64;
  localparam int DEF_FRAME_BYTES   = 64;
  localparam int DEF_MAX_READ_REGS = 29;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [15:0] CLAMP_HI = 16'd50;
  localparam logic [15:0] CLAMP_LO = 16'd1;
  localparam logic [16:0] CLAMP_IDX = 17'd52;
  localparam logic [15:0] SINGLE_IDX_A = 16'd30;
  localparam logic [15:0] SINGLE_IDX_B = 16'd32;

  localparam logic [1:0] OP_RX_BYTE   = 2'd0;
  localparam logic [1:0] OP_HOLD_RD   = 2'd1;
  localparam logic [1:0] OP_HOLD_WR   = 2'd2;
  localparam logic [1:0] OP_INPUT_WR  = 2'd3;

  localparam logic [7:0] FC_RD_COILS  = 8'h01;
  localparam logic [7:0] FC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FC_WR_COIL   = 8'h05;
  localparam logic [7:0] FC_WR_SINGLE = 8'h06;
  localparam logic [7:0] FC_WR_MULTI  = 8'h10;

  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic [5:0]  reg_index;
    logic [15:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic       init;
    logic       absorb;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic hold_we;
    logic input_we;
    logic re;
    logic rsel_input;
  } reg_ctrl_t;

  function automatic logic fc_supported(input logic [7:0] fc);
    return (fc == FC_RD_COILS) || (fc == FC_RD_HOLD) || (fc == FC_RD_INPUT) ||
           (fc == FC_WR_COIL) || (fc == FC_WR_SINGLE) || (fc == FC_WR_MULTI);
  endfunction

endpackage

FILE: hdl/mrtu_crc.sv
// ---------------------------------------------------------------------------
// CRC-16/MODBUS bit-serial unit
// Absorbs one byte, then shifts it through one bit per cycle.
// ---------------------------------------------------------------------------
module mrtu_crc
  import mrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  crc_cmd_t    cmd,
  output logic [15:0] crc,
  output logic        busy
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (cmd.init) begin
      crc_nxt = CRC_INIT;
      cnt_nxt = 4'd0;
    end else if (cmd.absorb) begin
      crc_nxt = crc_r ^ {8'h00, cmd.data};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (cnt_r != 4'd0);

endmodule

FILE: hdl/mrtu_regs.sv
// ---------------------------------------------------------------------------
// Register stores
// Holding and input register memories with per-entry valid bits.
// ---------------------------------------------------------------------------
module mrtu_regs
  import mrtu_pkg::*;
#(
  parameter int HOLDING_REGS = DEF_HOLDING_REGS,
  parameter int INPUT_REGS   = DEF_INPUT_REGS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  reg_ctrl_t   ctrl,
  input  logic [7:0]  waddr,
  input  logic [15:0] wdata,
  input  logic [7:0]  raddr,
  output logic [15:0] rdata
);

  localparam int HW = (HOLDING_REGS > 1) ? $clog2(HOLDING_REGS) : 1;
  localparam int IW = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;

  logic [15:0] hold_mem [HOLDING_REGS];
  logic [15:0] input_mem [INPUT_REGS];
  logic [HOLDING_REGS-1:0] hold_vld_r;
  logic [INPUT_REGS-1:0]   input_vld_r;
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctrl.hold_we) begin
      hold_mem[waddr[HW-1:0]] <= wdata;
    end
    if (ctrl.input_we) begin
      input_mem[waddr[IW-1:0]] <= wdata;
    end
    if (ctrl.re) begin
      if (ctrl.rsel_input) begin
        rdata_r <= input_vld_r[raddr[IW-1:0]] ? input_mem[raddr[IW-1:0]] : 16'h0000;
      end else begin
        rdata_r <= hold_vld_r[raddr[HW-1:0]] ? hold_mem[raddr[HW-1:0]] : 16'h0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r  <= '0;
      input_vld_r <= '0;
    end else begin
      if (ctrl.hold_we) begin
        hold_vld_r[waddr[HW-1:0]] <= 1'b1;
      end
      if (ctrl.input_we) begin
        input_vld_r[waddr[IW-1:0]] <= 1'b1;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/modbus_rtu_slave_frame_engine.sv
// ---------------------------------------------------------------------------
// Modbus RTU slave frame engine
// A received byte runs through the bit-serial CRC before the next is taken.
// A frame-ending byte then emits each response byte once the shared CRC
// unit is free; a multiple write first steps each register through S_WR_REQ0, S_WR_REQ1 and S_WR_DO.
// Local read: result passes the store's read register, then the output register,
// and waits longer under output stall; local writes go straight to the store.
// Synchronous active-low reset; the stores read zero via valid bits, no sweep.
// ---------------------------------------------------------------------------
module modbus_rtu_slave_frame_engine
  import mrtu_pkg::*;
#(
  parameter int HOLDING_REGS  = DEF_HOLDING_REGS,
  parameter int INPUT_REGS    = DEF_INPUT_REGS,
  parameter int FRAME_BYTES   = DEF_FRAME_BYTES,
  parameter int MAX_READ_REGS = DEF_MAX_READ_REGS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  // The frame buffer is indexed by the byte position; the count must also
  // hold FRAME_BYTES itself to detect overflow.
  localparam int BW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RXCRC, S_DECIDE, S_HDR, S_RD_REQ, S_RD_HI, S_RD_LO,
    S_WR_REQ0, S_WR_REQ1, S_WR_DO, S_CRC_LO, S_CRC_HI, S_LRD
  } state_t;

  typedef enum logic [1:0] { M_READ, M_ECHO, M_EXC } mode_t;

  state_t    state_r, state_nxt;
  mode_t     mode_r, mode_nxt;
  in_item_t  it_r, it_nxt;
  logic [7:0] dev_addr_r, dev_addr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0] h_r [7];
  logic [7:0] h_nxt [7];
  logic [15:0] start_r, start_nxt;
  logic [15:0] num_r, num_nxt;
  logic [8:0]  k_r, k_nxt;
  logic [2:0]  hk_r, hk_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  // Frame buffer memory.
  logic [7:0]    fbuf [FRAME_BYTES];
  logic          fb_we;
  logic [BW-1:0] fb_waddr;
  logic [BW-1:0] fb_raddr;
  logic [7:0]    fb_q;

  // Shared CRC unit and register stores.
  crc_cmd_t    crc_cmd;
  logic [15:0] crc;
  logic        crc_busy;
  reg_ctrl_t   rctl;
  logic [7:0]  r_waddr, r_raddr;
  logic [15:0] r_wdata, r_rdata;

  logic accept, out_free, emit_ok;
  logic [7:0]  fc;
  logic [15:0] req_start, req_num;
  logic [16:0] req_sum, req_num2, rd_size, wr_idx;
  logic [9:0]  bw_lo;
  logic [7:0]  hdr_byte;
  logic [2:0]  hdr_last;
  logic [15:0] wr_val;
  logic        frame_done;

  mrtu_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .crc   (crc),
    .busy  (crc_busy)
  );

  mrtu_regs #(
    .HOLDING_REGS (HOLDING_REGS),
    .INPUT_REGS   (INPUT_REGS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (rctl),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fbuf[fb_waddr] <= it_r.rx_byte;
    end
    fb_q <= fbuf[fb_raddr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  // The output register takes a new transaction when empty or draining.
  assign out_free  = !out_valid_r || !out_stall;
  // Response bytes also run through the CRC, so both must be free.
  assign emit_ok   = out_free && !crc_busy;

  assign fc        = h_r[1];
  assign req_start = {h_r[2], h_r[3]};
  assign req_num   = {h_r[4], h_r[5]};
  assign req_sum   = {1'b0, req_start} + {1'b0, req_num};
  assign req_num2  = {req_num, 1'b0};
  assign rd_size   = (fc == FC_RD_INPUT) ? 17'(INPUT_REGS) : 17'(HOLDING_REGS);
  assign wr_idx    = {1'b0, start_r} + {8'h00, k_r};
  assign bw_lo     = 10'd7 + {k_r, 1'b0};
  assign hdr_last  = (mode_r == M_ECHO) ? 3'd5 : 3'd2;

  // A function 0x10 frame is complete after 9 plus its byte count bytes.
  always_comb begin
    if (fc == FC_WR_MULTI) begin
      frame_done = (10'(count_r) == 10'd9 + {2'b00, h_r[6]}) && (10'(count_r) >= 10'd9);
    end else begin
      frame_done = (10'(count_r) == 10'd8);
    end
  end

  always_comb begin
    unique case (mode_r)
      M_ECHO: hdr_byte = h_r[hk_r];
      M_READ: begin
        unique case (hk_r)
          3'd0:    hdr_byte = h_r[0];
          3'd1:    hdr_byte = h_r[1];
          default: hdr_byte = {num_r[6:0], 1'b0};
        endcase
      end
      default: begin
        unique case (hk_r)
          3'd0:    hdr_byte = h_r[0];
          3'd1:    hdr_byte = h_r[1] | EXC_FLAG;
          default: hdr_byte = exc_r;
        endcase
      end
    endcase
  end

  // Register 52 of a multiple write is clamped to the range 1 to 50.
  always_comb begin
    wr_val = {hi_r, fb_q};
    if (wr_idx == CLAMP_IDX) begin
      if (wr_val < CLAMP_LO) begin
        wr_val = CLAMP_LO;
      end else if (wr_val > CLAMP_HI) begin
        wr_val = CLAMP_HI;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    it_nxt        = it_r;
    dev_addr_nxt  = dev_addr_r;
    count_nxt     = count_r;
    h_nxt         = h_r;
    start_nxt     = start_r;
    num_nxt       = num_r;
    k_nxt         = k_r;
    hk_nxt        = hk_r;
    exc_nxt       = exc_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    crc_cmd       = '0;
    rctl          = '0;
    r_waddr       = 8'(in_item.reg_index);
    r_wdata       = in_item.reg_value;
    r_raddr       = 8'(in_item.reg_index);
    fb_we         = 1'b0;
    fb_waddr      = count_r[BW-1:0];
    fb_raddr      = bw_lo[BW-1:0];

    if (cfg_valid && cfg_ready) begin
      dev_addr_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          it_nxt = in_item;
          unique case (in_item.operation)
            OP_RX_BYTE: state_nxt = S_RX;
            OP_HOLD_RD: begin
              rctl.re   = 1'b1;
              state_nxt = S_LRD;
            end
            OP_HOLD_WR: begin
              rctl.hold_we = (32'(in_item.reg_index) < HOLDING_REGS);
            end
            default: begin
              rctl.input_we = (32'(in_item.reg_index) < INPUT_REGS);
            end
          endcase
        end
      end

      S_LRD: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.kind       = KIND_LOCAL;
          out_item_nxt.tx_byte    = 8'h00;
          out_item_nxt.last       = 1'b0;
          out_item_nxt.read_value =
            (32'(it_r.reg_index) < HOLDING_REGS) ? r_rdata : 16'h0000;
          state_nxt = S_IDLE;
        end
      end

      S_RX: begin
        if (32'(count_r) >= FRAME_BYTES) begin
          // Overflow drops the whole frame.
          count_nxt    = '0;
          crc_cmd.init = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          fb_we     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (32'(count_r) < 7) begin
            h_nxt[count_r[2:0]] = it_r.rx_byte;
          end
          if ((count_r == '0) && (it_r.rx_byte != dev_addr_r) &&
              (it_r.rx_byte != 8'h00)) begin
            count_nxt    = '0;
            crc_cmd.init = 1'b1;
            state_nxt    = S_IDLE;
          end else if ((32'(count_r) == 1) && !fc_supported(it_r.rx_byte)) begin
            count_nxt    = '0;
            crc_cmd.init = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            crc_cmd.absorb = 1'b1;
            crc_cmd.data   = it_r.rx_byte;
            state_nxt      = S_RXCRC;
          end
        end
      end

      S_RXCRC: begin
        if (!crc_busy) begin
          if (!frame_done) begin
            state_nxt = S_IDLE;
          end else if (crc != 16'h0000) begin
            count_nxt    = '0;
            crc_cmd.init = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        // The frame is good: restart reception and seed the response CRC.
        count_nxt    = '0;
        crc_cmd.init = 1'b1;
        start_nxt    = req_start;
        num_nxt      = req_num;
        k_nxt        = '0;
        hk_nxt       = '0;
        state_nxt    = S_HDR;
        priority if ((fc == FC_RD_HOLD) || (fc == FC_RD_INPUT)) begin
          if ((req_num == 16'h0000) || (32'(req_num) > MAX_READ_REGS)) begin
            mode_nxt = M_EXC;
            exc_nxt  = EXC_VALUE;
          end else if (req_sum > rd_size) begin
            mode_nxt = M_EXC;
            exc_nxt  = EXC_ADDRESS;
          end else begin
            mode_nxt = M_READ;
          end
        end else if (fc == FC_WR_SINGLE) begin
          if (32'(req_start) >= HOLDING_REGS) begin
            mode_nxt = M_EXC;
            exc_nxt  = EXC_ADDRESS;
          end else begin
            mode_nxt     = M_ECHO;
            r_waddr      = req_start[7:0];
            r_wdata      = req_num;
            rctl.hold_we = (req_start == SINGLE_IDX_A) || (req_start == SINGLE_IDX_B);
          end
        end else if (fc == FC_WR_MULTI) begin
          if ((req_num == 16'h0000) || ({9'h000, h_r[6]} != req_num2)) begin
            mode_nxt = M_EXC;
            exc_nxt  = EXC_VALUE;
          end else if (req_sum > 17'(HOLDING_REGS)) begin
            mode_nxt = M_EXC;
            exc_nxt  = EXC_ADDRESS;
          end else begin
            mode_nxt  = M_ECHO;
            state_nxt = S_WR_REQ0;
          end
        end else begin
          // Functions 1 and 5 are accepted without a response.
          state_nxt = S_IDLE;
        end
      end

      S_WR_REQ0: begin
        fb_raddr  = bw_lo[BW-1:0];
        state_nxt = S_WR_REQ1;
      end

      S_WR_REQ1: begin
        hi_nxt    = fb_q;
        fb_raddr  = BW'(bw_lo + 10'd1);
        state_nxt = S_WR_DO;
      end

      S_WR_DO: begin
        rctl.hold_we = 1'b1;
        r_waddr      = wr_idx[7:0];
        r_wdata      = wr_val;
        k_nxt        = k_r + 9'd1;
        if (16'(k_r + 9'd1) == num_r) begin
          state_nxt = S_HDR;
        end else begin
          state_nxt = S_WR_REQ0;
        end
      end

      S_HDR: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{kind: KIND_LINE, tx_byte: hdr_byte, last: 1'b0,
                             read_value: 16'h0000};
          crc_cmd.absorb = 1'b1;
          crc_cmd.data   = hdr_byte;
          hk_nxt         = hk_r + 3'd1;
          if (hk_r == hdr_last) begin
            state_nxt = (mode_r == M_READ) ? S_RD_REQ : S_CRC_LO;
          end
        end
      end

      S_RD_REQ: begin
        rctl.re         = 1'b1;
        rctl.rsel_input = (fc == FC_RD_INPUT);
        r_raddr         = wr_idx[7:0];
        state_nxt       = S_RD_HI;
      end

      S_RD_HI: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{kind: KIND_LINE, tx_byte: r_rdata[15:8], last: 1'b0,
                             read_value: 16'h0000};
          crc_cmd.absorb = 1'b1;
          crc_cmd.data   = r_rdata[15:8];
          state_nxt      = S_RD_LO;
        end
      end

      S_RD_LO: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{kind: KIND_LINE, tx_byte: r_rdata[7:0], last: 1'b0,
                             read_value: 16'h0000};
          crc_cmd.absorb = 1'b1;
          crc_cmd.data   = r_rdata[7:0];
          k_nxt          = k_r + 9'd1;
          state_nxt      = (16'(k_r + 9'd1) == num_r) ? S_CRC_LO : S_RD_REQ;
        end
      end

      S_CRC_LO: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_LINE, tx_byte: crc[7:0], last: 1'b0,
                            read_value: 16'h0000};
          state_nxt     = S_CRC_HI;
        end
      end

      S_CRC_HI: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_LINE, tx_byte: crc[15:8], last: 1'b1,
                            read_value: 16'h0000};
          crc_cmd.init  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_ECHO;
      dev_addr_r  <= 8'd1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      dev_addr_r  <= dev_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    it_r       <= it_nxt;
    h_r        <= h_nxt;
    start_r    <= start_nxt;
    num_r      <= num_nxt;
    k_r        <= k_nxt;
    hk_r       <= hk_nxt;
    exc_r      <= exc_nxt;
    hi_r       <= hi_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
